// ----- hw/rtl/pee_pkg.sv -----
// Shared types and constants for the prefix expression evaluator.
package pee_pkg;

	localparam logic [7:0] SYM_ZERO = 8'h30;
	localparam logic [7:0] SYM_ADD  = 8'h2B;
	localparam logic [7:0] SYM_SUB  = 8'h2D;
	localparam logic [7:0] SYM_MUL  = 8'h2A;
	localparam logic [7:0] SYM_DIV  = 8'h2F;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_MISSING  = 3'd1;
	localparam logic [2:0] ERR_DIVZERO  = 3'd2;
	localparam logic [2:0] ERR_OVERFLOW = 3'd3;
	localparam logic [2:0] ERR_FULL     = 3'd4;

	localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic       done;
		logic [2:0] err;
	} alu_rsp_t;

endpackage

// ----- hw/rtl/pee_stack.sv -----
// Value stack storage: one write port, one registered read port.
module pee_stack import pee_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [63:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [63:0]   rd_data
);

	logic [63:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/pee_alu.sv -----
// Q32.32 arithmetic unit: direct add/sub, 4-pass multiply, bit-serial divide.
module pee_alu import pee_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  alu_req_t    req,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output alu_rsp_t    rsp,
	output logic [63:0] result
);

	typedef enum logic [2:0] {
		A_IDLE,
		A_MUL,
		A_DCHK,
		A_DIV,
		A_SAT,
		A_DONE
	} alu_state_t;

	alu_state_t   state_q;
	alu_op_t      op_q;
	logic [63:0]  ua_q, ub_q;
	logic         neg_q;
	logic [5:0]   cnt_q;
	logic [63:0]  pp_q;
	logic [127:0] acc_q;
	logic [63:0]  rem_q, lo_q, mag_q;
	logic         ovf_q;
	logic [63:0]  res_q;
	logic [2:0]   err_q;

	logic [63:0]  sum, diff, ua, ub;
	logic [31:0]  mul_a, mul_b;
	logic [64:0]  trial;
	logic [63:0]  sat_mag;
	logic         sat_ovf;

	assign sum   = a + b;
	assign diff  = a - b;
	assign ua    = a[63] ? (64'd0 - a) : a;
	assign ub    = b[63] ? (64'd0 - b) : b;
	assign mul_a = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
	assign mul_b = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
	assign trial = {rem_q, lo_q[63]};
	assign sat_mag = (op_q == OP_MUL) ? acc_q[95:32] : mag_q;
	assign sat_ovf = (op_q == OP_MUL) ? (|acc_q[127:96]) : ovf_q;

	assign rsp.done = (state_q == A_DONE);
	assign rsp.err  = err_q;
	assign result   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			op_q    <= OP_ADD;
			ua_q    <= '0;
			ub_q    <= '0;
			neg_q   <= 1'b0;
			cnt_q   <= '0;
			pp_q    <= '0;
			acc_q   <= '0;
			rem_q   <= '0;
			lo_q    <= '0;
			mag_q   <= '0;
			ovf_q   <= 1'b0;
			res_q   <= '0;
			err_q   <= ERR_NONE;
		end else begin
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						op_q  <= req.op;
						ua_q  <= ua;
						ub_q  <= ub;
						neg_q <= a[63] ^ b[63];
						cnt_q <= '0;
						acc_q <= '0;
						unique case (req.op)
							OP_ADD: begin
								if (a[63] == b[63] && sum[63] != a[63]) begin
									res_q <= a[63] ? Q_MIN : Q_MAX;
									err_q <= ERR_OVERFLOW;
								end else begin
									res_q <= sum;
									err_q <= ERR_NONE;
								end
								state_q <= A_DONE;
							end
							OP_SUB: begin
								if (a[63] != b[63] && diff[63] != a[63]) begin
									res_q <= a[63] ? Q_MIN : Q_MAX;
									err_q <= ERR_OVERFLOW;
								end else begin
									res_q <= diff;
									err_q <= ERR_NONE;
								end
								state_q <= A_DONE;
							end
							OP_MUL: begin
								err_q   <= ERR_NONE;
								state_q <= A_MUL;
							end
							OP_DIV: begin
								if (b == 64'd0) begin
									res_q   <= a[63] ? Q_MIN : Q_MAX;
									err_q   <= ERR_DIVZERO;
									state_q <= A_DONE;
								end else begin
									err_q   <= ERR_NONE;
									state_q <= A_DCHK;
								end
							end
							default: state_q <= A_IDLE;
						endcase
					end
				end
				A_MUL: begin
					// product of step k is registered in pp_q, then summed into acc_q
					if (cnt_q < 6'd4) begin
						pp_q <= mul_a * mul_b;
					end
					unique case (cnt_q[2:0])
						3'd1:        acc_q <= acc_q + {64'd0, pp_q};
						3'd2, 3'd3:  acc_q <= acc_q + {32'd0, pp_q, 32'd0};
						3'd4:        acc_q <= acc_q + {pp_q, 64'd0};
						default:     acc_q <= acc_q;
					endcase
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q[2:0] == 3'd4) begin
						state_q <= A_SAT;
					end
				end
				A_DCHK: begin
					if (ua_q[63:32] >= ub_q) begin
						mag_q   <= '0;
						ovf_q   <= 1'b1;
						state_q <= A_SAT;
					end else begin
						rem_q   <= {32'd0, ua_q[63:32]};
						lo_q    <= {ua_q[31:0], 32'd0};
						mag_q   <= '0;
						ovf_q   <= 1'b0;
						cnt_q   <= '0;
						state_q <= A_DIV;
					end
				end
				A_DIV: begin
					// restoring division, one quotient bit per cycle
					if (trial >= {1'b0, ub_q}) begin
						rem_q <= 64'(trial - {1'b0, ub_q});
						mag_q <= {mag_q[62:0], 1'b1};
					end else begin
						rem_q <= trial[63:0];
						mag_q <= {mag_q[62:0], 1'b0};
					end
					lo_q  <= {lo_q[62:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= A_SAT;
					end
				end
				A_SAT: begin
					if (!neg_q) begin
						if (sat_ovf || sat_mag[63]) begin
							res_q <= Q_MAX;
							err_q <= ERR_OVERFLOW;
						end else begin
							res_q <= sat_mag;
						end
					end else begin
						if (sat_ovf || sat_mag > Q_MIN) begin
							res_q <= Q_MIN;
							err_q <= ERR_OVERFLOW;
						end else begin
							res_q <= 64'd0 - sat_mag;
						end
					end
					state_q <= A_DONE;
				end
				A_DONE: begin
					state_q <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/prefix_expression_evaluator_unit.sv -----
// Top level of the prefix expression evaluator: sequencer around the stack and arithmetic unit.
//
// Input channel s_axis: one expression character per item, fed from the last
// character to the first. tdata holds the character code; tlast marks the
// first character of the expression (the last fed), which closes it.
// Output channel m_axis: one item per expression, sent after the tlast item.
// tdata is the top of stack as signed Q32.32, tuser the sticky error code
// (0 ok, 1 missing operand, 2 divide by zero, 3 overflow, 4 stack full).
// An operand is pushed as it is accepted; +, -, * and / pop two values and run
// through the arithmetic unit, * in four passes of one 32x32 multiplier and / with
// one quotient bit per cycle over 64 bits. A tlast item adds a read of the stack
// top, and no new item is taken before the last is done. The stack sits in a
// synchronous memory with registered reads; each pop is a read issued in the
// state before its data is used and pushes are written after the result. Reset
// clears the stack level, the error code and the output valid; the stack memory
// itself is not cleared. A stalled receiver only blocks the block when a new
// result is ready while the previous one is still held; other items are accepted meanwhile.
module prefix_expression_evaluator_unit import pee_pkg::*; #(
	parameter int STACK_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
	input  logic        s_axis_tlast,   // final_req
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [63:0] value
	output logic [2:0]  m_axis_tuser    // [2:0] error
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int LW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LEFT,
		S_RIGHT,
		S_ALU,
		S_TOP,
		S_OUT
	} seq_state_t;

	seq_state_t    state_q;
	logic [LW-1:0] level_q;
	logic [2:0]    err_q;
	alu_op_t       op_q;
	logic          fin_q;
	logic          pop_ok_q;
	logic [63:0]   left_q;
	logic          m_valid_q;
	logic [63:0]   m_data_q;
	logic [2:0]    m_user_q;

	logic          accept;
	logic          is_oper;
	logic          level_nz;
	logic          full;
	logic [LW-1:0] level_dec;
	logic [8:0]    digit;
	logic [63:0]   operand;
	alu_op_t       sym_op;

	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [63:0]   rd_data, wr_data;
	logic [63:0]   pop_data;

	alu_req_t      alu_req;
	alu_rsp_t      alu_rsp;
	logic [63:0]   alu_res;

	// first error of an expression wins
	function automatic logic [2:0] flag_err(input logic [2:0] cur, input logic [2:0] code);
		return (cur == ERR_NONE) ? code : cur;
	endfunction

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign is_oper   = (s_axis_tdata == SYM_ADD) || (s_axis_tdata == SYM_SUB) ||
	                   (s_axis_tdata == SYM_MUL) || (s_axis_tdata == SYM_DIV);
	assign level_nz  = (level_q != '0);
	assign full      = (level_q == LW'(STACK_DEPTH));
	assign level_dec = level_q - LW'(1);

	// operand value: (code - '0') as a whole number, sign carried into the integer part
	assign digit   = {1'b0, s_axis_tdata} - {1'b0, SYM_ZERO};
	assign operand = {{23{digit[8]}}, digit, 32'd0};

	always_comb begin
		unique case (s_axis_tdata)
			SYM_ADD: sym_op = OP_ADD;
			SYM_SUB: sym_op = OP_SUB;
			SYM_MUL: sym_op = OP_MUL;
			default: sym_op = OP_DIV;
		endcase
	end

	// pops read the top entry; the read data is registered in the stack
	assign rd_en   = (accept && is_oper && level_nz) ||
	                 ((state_q == S_LEFT || state_q == S_TOP) && level_nz);
	assign rd_addr = level_dec[AW-1:0];
	assign wr_en   = !full && ((accept && !is_oper) || (state_q == S_ALU && alu_rsp.done));
	assign wr_addr = level_q[AW-1:0];
	assign wr_data = (state_q == S_ALU) ? alu_res : operand;

	// an empty pop yields zero
	assign pop_data = pop_ok_q ? rd_data : 64'd0;

	assign alu_req.start = (state_q == S_RIGHT);
	assign alu_req.op    = op_q;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	pee_stack #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pee_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (left_q),
		.b      (pop_data),
		.rsp    (alu_rsp),
		.result (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			level_q   <= '0;
			err_q     <= ERR_NONE;
			op_q      <= OP_ADD;
			fin_q     <= 1'b0;
			pop_ok_q  <= 1'b0;
			left_q    <= '0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			m_user_q  <= ERR_NONE;
		end else begin
			// S_OUT reloads the output register itself
			if (m_valid_q && m_axis_tready && state_q != S_OUT) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q  <= sym_op;
						fin_q <= s_axis_tlast;
						if (is_oper) begin
							// left operand pop
							pop_ok_q <= level_nz;
							if (level_nz) begin
								level_q <= level_dec;
							end else begin
								err_q <= flag_err(err_q, ERR_MISSING);
							end
							state_q <= S_LEFT;
						end else begin
							if (!full) begin
								level_q <= level_q + LW'(1);
							end else begin
								err_q <= flag_err(err_q, ERR_FULL);
							end
							state_q <= s_axis_tlast ? S_TOP : S_IDLE;
						end
					end
				end
				S_LEFT: begin
					// capture left, pop right
					left_q   <= pop_data;
					pop_ok_q <= level_nz;
					if (level_nz) begin
						level_q <= level_dec;
					end else begin
						err_q <= flag_err(err_q, ERR_MISSING);
					end
					state_q <= S_RIGHT;
				end
				S_RIGHT: begin
					state_q <= S_ALU;
				end
				S_ALU: begin
					if (alu_rsp.done) begin
						if (!full) begin
							level_q <= level_q + LW'(1);
						end
						err_q <= flag_err(flag_err(err_q, alu_rsp.err),
						                  full ? ERR_FULL : ERR_NONE);
						state_q <= fin_q ? S_TOP : S_IDLE;
					end
				end
				S_TOP: begin
					pop_ok_q <= level_nz;
					if (!level_nz) begin
						err_q <= flag_err(err_q, ERR_MISSING);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					// hold until the output register is free
					if (!m_valid_q || m_axis_tready) begin
						m_data_q  <= pop_data;
						m_user_q  <= err_q;
						m_valid_q <= 1'b1;
						level_q   <= '0;
						err_q     <= ERR_NONE;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- bench/prefix_expression_evaluator_unit_tb.sv -----
// Self-checking testbench for the prefix expression evaluator: stream stimulus and result scoreboard.
module prefix_expression_evaluator_unit_tb;
	import pee_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          STACK_DEPTH    = 32;
	localparam int unsigned TOTAL_ITEMS    = 1800;
	// Longest legal quiet stretch is the long receiver hold plus one divide.
	localparam int unsigned LONG_HOLD      = 700;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	// Room for a divide still in flight and a closing item, with margin.
	localparam int unsigned DRAIN_CYCLES   = 200;

	typedef struct {
		logic [63:0] value;
		logic [2:0]  err;
	} expr_result_t;

	// Mixed: any operator, mostly small operands. Heavy: big operands and a
	// multiply for half of the operators, to drive values into saturation.
	typedef enum bit {
		EXPR_MIXED,
		EXPR_HEAVY
	} expr_kind_t;

	// Stack machine mirror of the block plus the queue of pending results.
	class expr_scoreboard;
		logic [63:0]  stack_mem [STACK_DEPTH];
		int unsigned  level;
		logic [2:0]   sticky_err;
		expr_result_t expected_q [$];
		int unsigned  fails;

		function new();
			level = 0;
			sticky_err = ERR_NONE;
			fails = 0;
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			fails++;
		endtask

		// First error of an expression wins until the closing item.
		function void flag_error(logic [2:0] code);
			if (sticky_err == ERR_NONE)
				sticky_err = code;
		endfunction

		function void push_value(logic [63:0] v);
			if (level >= STACK_DEPTH) begin
				flag_error(ERR_FULL);
				return;
			end
			stack_mem[level] = v;
			level++;
		endfunction

		function logic [63:0] pop_value();
			if (level == 0) begin
				flag_error(ERR_MISSING);
				return '0;
			end
			level--;
			return stack_mem[level];
		endfunction

		function logic [63:0] abs_q(logic [63:0] x);
			return x[63] ? -x : x;
		endfunction

		// Apply sign to a magnitude, clamping to the Q32.32 range.
		function logic [63:0] saturate(bit neg, logic [63:0] mag, bit ovf);
			if (!neg) begin
				if (ovf || mag > Q_MAX) begin
					flag_error(ERR_OVERFLOW);
					return Q_MAX;
				end
				return mag;
			end
			if (ovf || mag > Q_MIN) begin
				flag_error(ERR_OVERFLOW);
				return Q_MIN;
			end
			return -mag;
		endfunction

		function logic [63:0] add_q(logic [63:0] a, logic [63:0] b);
			logic [63:0] r;
			r = a + b;
			if (a[63] == b[63] && r[63] != a[63]) begin
				flag_error(ERR_OVERFLOW);
				return a[63] ? Q_MIN : Q_MAX;
			end
			return r;
		endfunction

		function logic [63:0] sub_q(logic [63:0] a, logic [63:0] b);
			logic [63:0] r;
			r = a - b;
			if (a[63] != b[63] && r[63] != a[63]) begin
				flag_error(ERR_OVERFLOW);
				return a[63] ? Q_MIN : Q_MAX;
			end
			return r;
		endfunction

		// Full 128-bit magnitude product, keep bits 95:32, truncating toward zero.
		function logic [63:0] mul_q(logic [63:0] a, logic [63:0] b);
			logic [127:0] prod;
			prod = {64'b0, abs_q(a)} * {64'b0, abs_q(b)};
			return saturate(a[63] ^ b[63], prod[95:32], prod[127:96] != 0);
		endfunction

		function logic [63:0] div_q(logic [63:0] a, logic [63:0] b);
			logic [63:0]  ua, ub;
			logic [127:0] quo;
			if (b == 0) begin
				flag_error(ERR_DIVZERO);
				return a[63] ? Q_MIN : Q_MAX;
			end
			ua = abs_q(a);
			ub = abs_q(b);
			// Quotient would not fit in 64 bits.
			if ({32'b0, ua[63:32]} >= ub)
				return saturate(a[63] ^ b[63], '0, 1'b1);
			quo = {32'b0, ua, 32'b0} / {64'b0, ub};
			return saturate(a[63] ^ b[63], quo[63:0], 1'b0);
		endfunction

		// One accepted input item; a closing item queues the expected result.
		function void note_symbol(logic [7:0] sym, logic last);
			logic [63:0]  left, right, r;
			expr_result_t res;
			case (sym)
				SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV: begin
					left = pop_value();
					right = pop_value();
					case (sym)
						SYM_ADD: r = add_q(left, right);
						SYM_SUB: r = sub_q(left, right);
						SYM_MUL: r = mul_q(left, right);
						default: r = div_q(left, right);
					endcase
					push_value(r);
				end
				default: begin
					r = {56'b0, sym} - 64'd48;
					push_value(r << 32);
				end
			endcase
			if (last) begin
				res.value = pop_value();
				res.err = sticky_err;
				expected_q.push_back(res);
				level = 0;
				sticky_err = ERR_NONE;
			end
		endfunction

		task check_result(logic [63:0] value, logic [2:0] err);
			expr_result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result with none pending: value=%h error=%0d",
					value, err));
				return;
			end
			want = expected_q.pop_front();
			if (value !== want.value)
				report_mismatch($sformatf("value %h, predicted %h", value, want.value));
			if (err !== want.err)
				report_mismatch($sformatf("error %0d, predicted %0d", err, want.err));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] symbol
	logic        s_axis_tlast;   // final_req
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;   // [63:0] value
	logic [2:0]  m_axis_tuser;   // [2:0] error

	expr_scoreboard sb = new();
	int unsigned    sent_items = 0;
	// Set by the stimulus, cleared by the result sink when its long hold ends.
	bit             hold_req = 1'b0;

	prefix_expression_evaluator_unit #(
		.STACK_DEPTH(STACK_DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 3);
		if (r < 90)
			return $urandom_range(4, 12);
		return $urandom_range(30, 90);
	endfunction

	function automatic logic [7:0] pick_operator(expr_kind_t kind);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (kind == EXPR_HEAVY) begin
			if (r < 50)
				return SYM_MUL;
			if (r < 70)
				return SYM_DIV;
			return (r < 85) ? SYM_ADD : SYM_SUB;
		end
		case (r % 4)
			0:       return SYM_ADD;
			1:       return SYM_SUB;
			2:       return SYM_MUL;
			default: return SYM_DIV;
		endcase
	endfunction

	function automatic logic [7:0] pick_operand(expr_kind_t kind);
		int unsigned r;
		logic [7:0]  sym;
		r = $urandom_range(0, 99);
		if (kind == EXPR_HEAVY && r < 85)
			return 8'($urandom_range(8'h80, 8'hFF));
		if (r < 60)
			return SYM_ZERO + 8'($urandom_range(0, 9));
		// Extra zeros so divides by zero come up often.
		if (r < 70)
			return SYM_ZERO;
		// Largest and most negative operand.
		if (r < 80)
			return r[0] ? 8'hFF : 8'h00;
		sym = 8'($urandom);
		// Keep a well-formed sequence: fold operator codes onto operands.
		if (sym inside {SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV})
			sym ^= 8'h80;
		return sym;
	endfunction

	// Drive one item and hold it until accepted. Entered and left on a rising
	// edge; tvalid stays high into the next item when no gap is drawn.
	task automatic send_symbol(input logic [7:0] sym, input logic last, input bit idle_ok);
		int unsigned gap;
		gap = (idle_ok && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= sym;
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sent_items++;
	endtask

	// Characters in feed order; the last one closes the expression.
	task automatic send_text(input string text);
		for (int i = 0; i < text.len(); i++)
			send_symbol(8'(text[i]), i == text.len() - 1, 1'b1);
	endtask

	// Well-formed expression in feed order: an operator only when two values
	// are on the stack, the final item leaves exactly one.
	task automatic send_expression(input expr_kind_t kind, input int unsigned n_ops,
		input bit idle_ok);
		int unsigned operands_left, ops_left, depth;
		bit          take_op;
		logic [7:0]  sym;
		operands_left = n_ops + 1;
		ops_left = n_ops;
		depth = 0;
		while (operands_left + ops_left > 0) begin
			take_op = ops_left > 0 && depth >= 2 &&
				(operands_left == 0 || $urandom_range(0, 2) == 0);
			if (take_op) begin
				sym = pick_operator(kind);
				ops_left--;
				depth--;
			end else begin
				sym = pick_operand(kind);
				operands_left--;
				depth++;
			end
			send_symbol(sym, operands_left + ops_left == 0, idle_ok);
		end
	endtask

	// Stop offering items until every pending result is out, then let any
	// divide still in flight finish.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.expected_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Result side: random stalls, calm stretches, and one long hold on request.
	initial begin : result_sink
		int unsigned stall, span;
		bit          steady;
		stall = 0;
		span = 0;
		steady = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (span == 0) begin
				steady = $urandom_range(0, 3) == 0;
				span = $urandom_range(100, 400);
			end else begin
				span--;
			end
			if (hold_req) begin
				// Long hold: the block fills up and must stall its input.
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				m_axis_tready <= 1'b1;
				hold_req = 1'b0;
			end else if (stall != 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
				if (!steady && $urandom_range(0, 5) == 0)
					stall = pick_gap();
			end
		end
	end

	// Both channels are sampled here, input first, so every item is noted
	// before any result it causes. The watchdog ends a run that stops moving.
	initial begin : monitor
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			quiet++;
			if (s_axis_tvalid && s_axis_tready) begin
				sb.note_symbol(s_axis_tdata, s_axis_tlast);
				quiet = 0;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tdata, m_axis_tuser);
				quiet = 0;
			end
		end
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		int unsigned r, n;
		bit          idle_ok, did_hold, did_pause;
		did_hold = 1'b0;
		did_pause = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: operand extremes, lone operator on an empty stack.
		send_symbol(SYM_ZERO, 1'b1, 1'b1);
		send_symbol(8'hFF, 1'b1, 1'b1);
		send_symbol(8'h00, 1'b1, 1'b1);
		send_symbol(SYM_ADD, 1'b1, 1'b1);
		// Subtract, multiply and divide; the first popped value is the left operand.
		send_text("05/");
		send_text("32-");
		send_text("98*");
		send_text("31/");
		// Negative dividend over zero saturates to the minimum.
		send_symbol(SYM_ZERO, 1'b0, 1'b1);
		send_symbol(8'h00, 1'b0, 1'b1);
		send_symbol(SYM_DIV, 1'b1, 1'b1);
		// 207 to the fifth power overflows the multiply.
		repeat (5) send_symbol(8'hFF, 1'b0, 1'b1);
		send_text("****");
		wait_drained();

		// Random: mostly well-formed expressions, some deep stacks and noise.
		while (sent_items < TOTAL_ITEMS) begin
			idle_ok = $urandom_range(0, 4) != 0;
			r = $urandom_range(0, 99);
			if (!did_hold && sent_items > 600) begin
				// Sender keeps offering short expressions while results back up.
				did_hold = 1'b1;
				hold_req = 1'b1;
				repeat (12) send_expression(EXPR_MIXED, $urandom_range(0, 2), 1'b0);
			end else if (!did_pause && sent_items > 1200) begin
				did_pause = 1'b1;
				wait_drained();
			end else if (r < 60) begin
				send_expression(EXPR_MIXED, $urandom_range(0, 8), idle_ok);
			end else if (r < 80) begin
				send_expression(EXPR_HEAVY, $urandom_range(4, 7), idle_ok);
			end else if (r < 84) begin
				// Deep stack: push near or past the top, then fold some of it back.
				n = $urandom_range(30, 36);
				repeat (n) send_symbol(pick_operand(EXPR_MIXED), 1'b0, idle_ok);
				repeat ($urandom_range(0, n)) send_symbol(pick_operator(EXPR_MIXED), 1'b0,
					idle_ok);
				send_symbol(pick_operator(EXPR_MIXED), 1'b1, idle_ok);
			end else begin
				// Noise: arbitrary codes and closings, broken expressions.
				repeat ($urandom_range(1, 10)) begin
					if ($urandom_range(0, 9) < 3)
						send_symbol(pick_operator(EXPR_MIXED), $urandom_range(0, 4) == 0,
							idle_ok);
					else
						send_symbol(8'($urandom), $urandom_range(0, 4) == 0, idle_ok);
				end
			end
		end

		wait_drained();
		if (sb.fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- prefix_expression_evaluator_unit.f -----
hw/rtl/pee_pkg.sv
hw/rtl/pee_stack.sv
hw/rtl/pee_alu.sv
hw/rtl/prefix_expression_evaluator_unit.sv
bench/prefix_expression_evaluator_unit_tb.sv
